FILE: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 16;
  localparam int COUNT_W = 7;
  localparam int STATUS_W = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
  } entry_t;

  typedef struct packed {
    logic   insert;
    logic   remove;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

FILE: hdl/spq_if.sv
// ----------------------------------------------------------------------------
// spq_if
// Request and response channels of the sorted priority queue.
// ----------------------------------------------------------------------------
interface spq_req_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic signed [spq_pkg::VALUE_W-1:0]  item_value;
  logic signed [spq_pkg::PRIO_W-1:0]   item_priority;

  modport source (output valid, output operation, output item_value,
                  output item_priority, input ready);
  modport sink   (input valid, input operation, input item_value,
                  input item_priority, output ready);
endinterface

interface spq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [spq_pkg::STATUS_W-1:0]        status;
  logic signed [spq_pkg::VALUE_W-1:0]  removed_value;
  logic [spq_pkg::COUNT_W-1:0]         entry_count;

  modport source (output valid, output status, output removed_value,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input removed_value,
                  input entry_count, output ready);
endinterface

FILE: hdl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: keeps its entry, takes the new entry, or
// takes a neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic                occupied,
  input  spq_pkg::entry_t     left,
  input  logic                left_keep,
  input  spq_pkg::entry_t     right,
  output spq_pkg::entry_t     held,
  output logic                keep
);

  // entry stays in place on insert when it sorts at or ahead of the new one
  assign keep = occupied && !(held.prio > ctrl.new_entry.prio);

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (!keep) begin
        if (left_keep) begin
          held <= ctrl.new_entry;
        end else begin
          held <= left;
        end
      end
    end else if (ctrl.remove) begin
      held <= right;
    end
  end

endmodule

FILE: hdl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue held in a chain of cells, sorted by ascending priority.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one transaction per operation: operation 0 inserts
//   item_value with item_priority, operation 1 removes the head entry.
//   rsp returns one transaction per request: status (ok, full, empty),
//   removed_value (head value on a good remove, zero otherwise) and the
//   entry count after the operation.
//   Equal priorities leave in arrival order.
//   The response is registered; with rsp ready, one request per cycle
//   is taken. Every cell compares its priority with the new one and moves
//   in the same cycle, so the rate is set by the 16-bit compare per cell.
//   req.ready is high when the response register is empty or is being
//   taken; a stalled receiver holds the response and blocks new requests.
//   Reset empties the queue and drops any pending response; entry
//   contents are not cleared, the count alone marks which cells hold data.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  spq_req_if.sink      req,
  spq_rsp_if.source    rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic                accept;
  logic                full;
  logic                empty;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t     held [DEPTH];
  logic                keep [DEPTH];
  logic [DEPTH-1:0]    occupied;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);

  always_comb begin
    ctrl.insert          = accept && (req.operation == spq_pkg::OP_INSERT) && !full;
    ctrl.remove          = accept && (req.operation == spq_pkg::OP_REMOVE) && !empty;
    ctrl.new_entry.value = req.item_value;
    ctrl.new_entry.prio  = req.item_priority;
  end

  always_comb begin
    count_next = count;
    if (ctrl.insert) begin
      count_next = count + CW'(1);
    end else if (ctrl.remove) begin
      count_next = count - CW'(1);
    end
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      assign occupied[i] = (CW'(i) < count);
      if (i == 0) begin : g_head
        spq_cell u_cell (
          .clk       (clk),
          .ctrl      (ctrl),
          .occupied  (occupied[i]),
          .left      (held[i]),
          .left_keep (1'b1),
          .right     (held[(DEPTH > 1) ? 1 : 0]),
          .held      (held[i]),
          .keep      (keep[i])
        );
      end else if (i == DEPTH - 1) begin : g_tail
        spq_cell u_cell (
          .clk       (clk),
          .ctrl      (ctrl),
          .occupied  (occupied[i]),
          .left      (held[i-1]),
          .left_keep (keep[i-1]),
          .right     (held[i]),
          .held      (held[i]),
          .keep      (keep[i])
        );
      end else begin : g_mid
        spq_cell u_cell (
          .clk       (clk),
          .ctrl      (ctrl),
          .occupied  (occupied[i]),
          .left      (held[i-1]),
          .left_keep (keep[i-1]),
          .right     (held[i+1]),
          .held      (held[i]),
          .keep      (keep[i])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  logic [spq_pkg::COUNT_W-1:0] count_field;
  generate
    if (CW >= spq_pkg::COUNT_W) begin : g_cnt_trunc
      assign count_field = count_next[spq_pkg::COUNT_W-1:0];
    end else begin : g_cnt_ext
      assign count_field = {{(spq_pkg::COUNT_W-CW){1'b0}}, count_next};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.entry_count <= count_field;
      if (req.operation == spq_pkg::OP_INSERT) begin
        rsp.status        <= full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
        rsp.removed_value <= '0;
      end else begin
        rsp.status        <= empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
        rsp.removed_value <= empty ? '0 : held[0].value;
      end
    end
  end

endmodule

FILE: bench/sorted_priority_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_test
// Self-checking bench for the sorted priority queue. A directed table covers
// the field extremes, equal priorities, remove on empty and ignored fields.
// Random phases then push the queue to full and drain it to empty. Every
// response is checked against the table or a sorted-array predictor, field by
// field, under random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test;

  localparam int QUEUE_DEPTH  = 64;
  localparam int HALF_PERIOD  = 5;
  localparam int RANDOM_ITEMS = 800;
  localparam int CALM_ITEMS   = 100;
  localparam int HOLD_CYCLES  = 300;
  localparam int NUM_ROWS     = 18;

  typedef struct packed {
    logic [spq_pkg::STATUS_W-1:0]       status;
    logic signed [spq_pkg::VALUE_W-1:0] removed;
    logic [spq_pkg::COUNT_W-1:0]        count;
  } reply_t;

  typedef struct packed {
    logic                               op;
    logic signed [spq_pkg::VALUE_W-1:0] value;
    logic signed [spq_pkg::PRIO_W-1:0]  prio;
    logic                               known;
    reply_t                             reply;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  spq_req_if req ();
  spq_rsp_if rsp ();

  sorted_priority_queue #(.DEPTH(QUEUE_DEPTH)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #HALF_PERIOD clk = ~clk;

  logic signed [spq_pkg::VALUE_W-1:0] held_value [QUEUE_DEPTH];
  logic signed [spq_pkg::PRIO_W-1:0]  held_prio  [QUEUE_DEPTH];
  int                                 held_count = 0;

  reply_t pending_replies [$];
  int     error_count  = 0;
  bit     tail_phase   = 1'b0;
  bit     hold_request = 1'b0;

  // ordered by ascending priority, ties in arrival order
  function automatic reply_t apply_operation(logic op,
                                             logic signed [spq_pkg::VALUE_W-1:0] val,
                                             logic signed [spq_pkg::PRIO_W-1:0] pr);
    reply_t r;
    int     pos;
    r = '0;
    r.status = spq_pkg::ST_OK;
    if (op == spq_pkg::OP_INSERT) begin
      if (held_count >= QUEUE_DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = held_count;
        while (pos > 0 && held_prio[pos-1] > pr) begin
          held_value[pos] = held_value[pos-1];
          held_prio[pos]  = held_prio[pos-1];
          pos--;
        end
        held_value[pos] = val;
        held_prio[pos]  = pr;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        r.removed = held_value[0];
        for (int k = 0; k + 1 < held_count; k++) begin
          held_value[k] = held_value[k+1];
          held_prio[k]  = held_prio[k+1];
        end
        held_count--;
      end
    end
    r.count = held_count[spq_pkg::COUNT_W-1:0];
    return r;
  endfunction

  task automatic offer(input stim_row_t row);
    reply_t predicted;
    @(negedge clk);
    req.valid         <= 1'b1;
    req.operation     <= row.op;
    req.item_value    <= row.value;
    req.item_priority <= row.prio;
    do @(posedge clk); while (!req.ready);
    predicted = apply_operation(row.op, row.value, row.prio);
    pending_replies.push_back(row.known ? row.reply : predicted);
  endtask

  task automatic pause_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      req.valid <= 1'b0;
    end
  endtask

  task automatic maybe_gap();
    if (!tail_phase && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 16));
  endtask

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{spq_pkg::OP_REMOVE, 32'sh0000_0000, 16'sh0000, 1'b1, '{spq_pkg::ST_EMPTY, 32'sh0, 7'd0}},
    '{spq_pkg::OP_INSERT, 32'sh7fff_ffff, 16'sh7fff, 1'b1, '{spq_pkg::ST_OK, 32'sh0, 7'd1}},
    '{spq_pkg::OP_INSERT, 32'sh8000_0000, 16'sh8000, 1'b1, '{spq_pkg::ST_OK, 32'sh0, 7'd2}},
    '{spq_pkg::OP_INSERT, 32'sh0000_0000, 16'sh0000, 1'b1, '{spq_pkg::ST_OK, 32'sh0, 7'd3}},
    '{spq_pkg::OP_INSERT, 32'shffff_ffff, 16'sh0000, 1'b1, '{spq_pkg::ST_OK, 32'sh0, 7'd4}},
    '{spq_pkg::OP_INSERT, 32'sh5555_5555, 16'sh5555, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 32'shaaaa_aaaa, 16'shaaaa, 1'b0, '0},
    '{spq_pkg::OP_INSERT, 32'sh1234_5678, 16'sh8000, 1'b0, '0},
    '{spq_pkg::OP_REMOVE, 32'sh0000_0000, 16'sh0000, 1'b1,
      '{spq_pkg::ST_OK, 32'sh8000_0000, 7'd6}},
    '{spq_pkg::OP_REMOVE, 32'sh0000_0000, 16'sh0000, 1'b0, '0},
    '{spq_pkg::OP_REMOVE, 32'sh0000_0000, 16'sh0000, 1'b0, '0},
    '{spq_pkg::OP_REMOVE, 32'sh0000_0000, 16'sh0000, 1'b0, '0},
    '{spq_pkg::OP_REMOVE, 32'sh0000_0000, 16'sh0000, 1'b0, '0},
    '{spq_pkg::OP_REMOVE, 32'sh0000_0000, 16'sh0000, 1'b0, '0},
    '{spq_pkg::OP_REMOVE, 32'sh0000_0000, 16'sh0000, 1'b0, '0},
    '{spq_pkg::OP_REMOVE, 32'shffff_ffff, 16'shffff, 1'b1, '{spq_pkg::ST_EMPTY, 32'sh0, 7'd0}},
    '{spq_pkg::OP_INSERT, 32'sh0000_0001, 16'sh0001, 1'b0, '0},
    '{spq_pkg::OP_REMOVE, 32'shffff_ffff, 16'shffff, 1'b0, '0}
  };

  initial begin
    stim_row_t row;
    int        sent;
    int        phase;
    int        phase_len;
    int        insert_pct;
    req.valid         = 1'b0;
    req.operation     = spq_pkg::OP_INSERT;
    req.item_value    = '0;
    req.item_priority = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_ROWS; i++) begin
      maybe_gap();
      offer(directed_rows[i]);
    end

    // alternate fill, drain and mixed phases so full and empty both recur
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase % 3)
        0:       insert_pct = 85;
        1:       insert_pct = 15;
        default: insert_pct = 50;
      endcase
      phase_len = $urandom_range(80, 150);
      for (int j = 0; j < phase_len && sent < RANDOM_ITEMS; j++) begin
        row       = '0;
        row.op    = ($urandom_range(1, 100) <= insert_pct) ? spq_pkg::OP_INSERT
                                                           : spq_pkg::OP_REMOVE;
        row.value = ($urandom_range(0, 7) == 0) ?
                    ($urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000) : $urandom;
        case ($urandom_range(0, 3))
          0:       row.prio = 16'($urandom);
          1:       row.prio = 16'($urandom_range(0, 4) - 2);
          2:       row.prio = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          default: row.prio = 16'($urandom_range(0, 15));
        endcase
        if (sent == RANDOM_ITEMS / 2) hold_request = 1'b1;
        if (sent >= RANDOM_ITEMS - CALM_ITEMS) tail_phase = 1'b1;
        maybe_gap();
        offer(row);
        sent++;
      end
      phase++;
    end
    pause_sender(1);

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    int n;
    rsp.ready = 1'b0;
    wait (!rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          rsp.ready <= 1'b0;
        end
      end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 16);
        repeat (n) begin
          @(negedge clk);
          rsp.ready <= 1'b0;
        end
      end else begin
        n = $urandom_range(1, 24);
        repeat (n) begin
          @(negedge clk);
          rsp.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_replies.size() == 0) begin
        $display("%t unexpected response transaction: status %0d value %0d count %0d",
                 $time, rsp.status, rsp.removed_value, rsp.entry_count);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        if (rsp.status !== want.status) begin
          $display("%t status: expected %0d, got %0d", $time, want.status, rsp.status);
          error_count++;
        end
        if (rsp.removed_value !== want.removed) begin
          $display("%t removed_value: expected %0d, got %0d",
                   $time, want.removed, rsp.removed_value);
          error_count++;
        end
        if (rsp.entry_count !== want.count) begin
          $display("%t entry_count: expected %0d, got %0d",
                   $time, want.count, rsp.entry_count);
          error_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: sorted_priority_queue.f
hdl/spq_pkg.sv
hdl/spq_if.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
bench/sorted_priority_queue_test.sv
